// File: src/fvn_pkg.sv
// ----------------------------------------------------------------------------
// fvn_pkg
// Constants and helpers shared by the fractal value noise pipeline: hash
// multipliers, scroll rates, channel offsets and the reciprocal table used
// for the final normalization.
// ----------------------------------------------------------------------------
package fvn_pkg;

	localparam int MAX_OCTAVES_DEF = 6;

	localparam logic REG_OCTAVE_COUNT = 1'b0;

	localparam logic [31:0] HASH_MUL_X = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
	localparam logic [31:0] HASH_MUL_Z = 32'd2147483647;
	localparam logic [31:0] HASH_MIX   = 32'd1274126177;

	localparam logic [31:0] HASH_MUL [3] = '{HASH_MUL_X, HASH_MUL_Y, HASH_MUL_Z};

	localparam logic signed [16:0] SCROLL_RATE [3] = '{
		17'sd24248, 17'sd15073, -17'sd20316
	};

	localparam logic signed [31:0] CHAN_OFFSET [3][3] = '{
		'{32'sd1120666, 32'sd216269, 32'sd373555},
		'{-32'sd602931, 32'sd747110, 32'sd124518},
		'{32'sd288358, -32'sd511181, 32'sd891290}
	};

	// ceil(2^32 / (2^k - 1)) for k = 1..8, indexed by k - 1.
	localparam logic [32:0] DIV_RECIP [8] = '{
		33'd4294967296, 33'd1431655766, 33'd613566757, 33'd286331154,
		33'd138547333, 33'd68174085, 33'd33818641, 33'd16843010
	};

	function automatic logic [31:0] corner_add(logic [2:0] idx);
		logic [31:0] s;
		s = '0;
		if (idx[0]) s = s + HASH_MUL_X;
		if (idx[1]) s = s + HASH_MUL_Y;
		if (idx[2]) s = s + HASH_MUL_Z;
		return s;
	endfunction

endpackage

// File: src/fvn_point_if.sv
// ----------------------------------------------------------------------------
// fvn_point_if
// Valid/ready channel that carries one query point and its scroll time.
// ----------------------------------------------------------------------------
interface fvn_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] sample_time;

	modport source (output valid, pos_x, pos_y, pos_z, sample_time, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, sample_time, output ready);
endinterface

// File: src/fvn_noise_if.sv
// ----------------------------------------------------------------------------
// fvn_noise_if
// Valid/ready channel that carries the three noise channels of one point.
// ----------------------------------------------------------------------------
interface fvn_noise_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] noise_x;
	logic signed [15:0] noise_y;
	logic signed [15:0] noise_z;

	modport source (output valid, noise_x, noise_y, noise_z, input ready);
	modport sink (input valid, noise_x, noise_y, noise_z, output ready);
endinterface

// File: src/fvn_lattice.sv
// ----------------------------------------------------------------------------
// fvn_lattice
// Seven-stage value noise evaluator: corner hashing, smoothstep weights and
// trilinear interpolation of one lattice cell.
// ----------------------------------------------------------------------------
module fvn_lattice (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        cell_idx [3],
	input  logic [15:0]        frac [3],
	output logic signed [15:0] value
);

	logic [31:0]        m_s1 [3];
	logic [15:0]        u2_s1 [3];
	logic [15:0]        u_s1 [3];
	logic [31:0]        h_s2 [8];
	logic [16:0]        w_s2 [3];
	logic [31:0]        g_s3 [8];
	logic [16:0]        w_s3 [3];
	logic signed [15:0] a_s4 [4];
	logic signed [34:0] p_s4 [4];
	logic [16:0]        w1_s4;
	logic [16:0]        w2_s4;
	logic signed [15:0] a_s5 [2];
	logic signed [34:0] p_s5 [2];
	logic [16:0]        w2_s5;
	logic signed [15:0] a_s6;
	logic signed [34:0] p_s6;

	function automatic logic signed [34:0] lerp_mul(logic signed [15:0] a,
			logic signed [15:0] b, logic [16:0] w);
		logic signed [16:0] d;
		d = 17'(a);
		d = 17'(b) - d;
		return 35'(d * $signed({1'b0, w}));
	endfunction

	function automatic logic signed [15:0] lerp_fin(logic signed [15:0] a,
			logic signed [34:0] p);
		logic signed [18:0] s;
		s = 19'(a) + 19'(p >>> 16);
		return s[15:0];
	endfunction

	logic [63:0]        hm [3];
	logic [31:0]        uu [3];
	logic [33:0]        ws [3];
	logic [31:0]        hx [8];
	logic [63:0]        gm [8];
	logic [31:0]        f [8];
	logic signed [15:0] v [8];
	logic signed [15:0] x4 [4];
	logic signed [15:0] y2 [2];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			hm[a] = {32'd0, cell_idx[a]} * {32'd0, fvn_pkg::HASH_MUL[a]};
			uu[a] = {16'd0, frac[a]} * {16'd0, frac[a]};
			ws[a] = {18'd0, u2_s1[a]} * {16'd0, 18'd196608 - {1'b0, u_s1[a], 1'b0}};
		end
		for (int i = 0; i < 8; i++) begin
			hx[i] = h_s2[i] ^ (h_s2[i] >> 13);
			gm[i] = {32'd0, hx[i]} * {32'd0, fvn_pkg::HASH_MIX};
			f[i]  = g_s3[i] ^ (g_s3[i] >> 16);
			v[i]  = $signed({~f[i][23], f[i][22:8]});
		end
		for (int j = 0; j < 4; j++) x4[j] = lerp_fin(a_s4[j], p_s4[j]);
		for (int j = 0; j < 2; j++) y2[j] = lerp_fin(a_s5[j], p_s5[j]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				m_s1[a]  <= hm[a][31:0];
				u2_s1[a] <= uu[a][31:16];
				u_s1[a]  <= frac[a];
				w_s2[a]  <= ws[a][32:16];
				w_s3[a]  <= w_s2[a];
			end
			for (int i = 0; i < 8; i++) begin
				h_s2[i] <= m_s1[0] + m_s1[1] + m_s1[2] + fvn_pkg::corner_add(3'(i));
				g_s3[i] <= gm[i][31:0];
			end
			for (int j = 0; j < 4; j++) begin
				a_s4[j] <= v[2*j];
				p_s4[j] <= lerp_mul(v[2*j], v[2*j+1], w_s3[0]);
			end
			w1_s4 <= w_s3[1];
			w2_s4 <= w_s3[2];
			a_s5[0] <= x4[0];
			p_s5[0] <= lerp_mul(x4[0], x4[1], w1_s4);
			a_s5[1] <= x4[2];
			p_s5[1] <= lerp_mul(x4[2], x4[3], w1_s4);
			w2_s5 <= w2_s4;
			a_s6 <= y2[0];
			p_s6 <= lerp_mul(y2[0], y2[1], w2_s5);
			value <= lerp_fin(a_s6, p_s6);
		end
	end

endmodule

// File: src/fractal_value_noise_3d_core.sv
// ----------------------------------------------------------------------------
// fractal_value_noise_3d_core
// Three-channel fractal value noise over a 3-D point scrolled by time.
// ----------------------------------------------------------------------------
// A point word (pos_x, pos_y, pos_z, sample_time, all signed Q16.16) enters on
// the points channel; the matching noise word (noise_x, noise_y, noise_z,
// signed Q1.15) leaves on the noise channel. Both channels are valid/ready.
// The APB port holds one register, octave_count at address 0, which sets how
// many octaves are summed (zero counts as one, larger values saturate at
// MAX_OCTAVES). Write it only while no word is in flight.
// Every octave and channel has its own lattice evaluator, so one word is
// accepted per cycle while the receiver keeps taking results.
// The 14 stages advance together: when the output register holds a word the
// receiver does not take, the whole pipeline holds and points.ready drops,
// and no word is lost or repeated. Reset empties the pipeline and sets
// octave_count to one.
// ----------------------------------------------------------------------------
module fractal_value_noise_3d_core #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fvn_point_if.sink   points,
	fvn_noise_if.source noise,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LAT = 14;

	logic [2:0]      oct_q;
	logic [3:0]      kc;
	logic            en;
	logic [LAT:1]    vld_s;

	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] time_s1;
	logic signed [31:0] pos_s2 [3];
	logic signed [48:0] scr_s2 [3];
	logic signed [15:0] nz [MAX_OCTAVES][3];
	logic signed [24:0] acc_s11 [3];
	logic [24:0]        num_s12 [3];
	logic               neg_s12 [3];
	logic [57:0]        prod_s13 [3];
	logic               neg_s13 [3];
	logic signed [15:0] out_s14 [3];

	assign pready = 1'b1;
	assign prdata = (paddr[2] == fvn_pkg::REG_OCTAVE_COUNT) ? {29'd0, oct_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q <= 3'd1;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == fvn_pkg::REG_OCTAVE_COUNT) begin
			oct_q <= pwdata[2:0];
		end
	end

	always_comb begin
		if (oct_q == 3'd0) kc = 4'd1;
		else if ({1'b0, oct_q} > 4'(MAX_OCTAVES)) kc = 4'(MAX_OCTAVES);
		else kc = {1'b0, oct_q};
	end

	assign en = !vld_s[LAT] || noise.ready;
	assign points.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], points.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1[0] <= points.pos_x;
			pos_s1[1] <= points.pos_y;
			pos_s1[2] <= points.pos_z;
			time_s1   <= points.sample_time;
			for (int a = 0; a < 3; a++) begin
				pos_s2[a] <= pos_s1[a];
				scr_s2[a] <= 49'(time_s1 * fvn_pkg::SCROLL_RATE[a]);
			end
		end
	end

	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
		for (genvar ch = 0; ch < 3; ch++) begin : g_ch
			logic signed [47:0] q [3];
			logic [31:0]        cell_s3 [3];
			logic [15:0]        frac_s3 [3];
			logic signed [15:0] val;

			always_comb begin
				for (int a = 0; a < 3; a++) begin
					q[a] = (48'(pos_s2[a]) <<< o) + 48'(scr_s2[a] >>> 16) +
						48'(fvn_pkg::CHAN_OFFSET[ch][a]);
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					for (int a = 0; a < 3; a++) begin
						cell_s3[a] <= q[a][47:16];
						frac_s3[a] <= q[a][15:0];
					end
				end
			end

			fvn_lattice u_lattice (
				.clk      (clk),
				.en       (en),
				.cell_idx (cell_s3),
				.frac     (frac_s3),
				.value    (val)
			);

			assign nz[o][ch] = val;
		end
	end

	logic signed [24:0] acc [3];
	logic signed [24:0] mag [3];
	logic [24:0]        half;
	logic [3:0]         sh;
	logic [16:0]        quo [3];

	always_comb begin
		half = 25'((25'd1 << (kc - 4'd1)) - 25'd1);
		sh = '0;
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = '0;
			for (int o = 0; o < MAX_OCTAVES; o++) begin
				sh = kc - 4'd1 - 4'(o);
				if (4'(o) < kc) acc[ch] = acc[ch] + (25'(nz[o][ch]) <<< sh);
			end
			mag[ch] = acc_s11[ch][24] ? -acc_s11[ch] : acc_s11[ch];
			quo[ch] = prod_s13[ch][48:32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_s11[ch]  <= acc[ch];
				num_s12[ch]  <= mag[ch] + half;
				neg_s12[ch]  <= acc_s11[ch][24];
				prod_s13[ch] <= 58'(num_s12[ch] * fvn_pkg::DIV_RECIP[3'(kc - 4'd1)]);
				neg_s13[ch]  <= neg_s12[ch];
				out_s14[ch]  <= neg_s13[ch] ? -quo[ch][15:0] : quo[ch][15:0];
			end
		end
	end

	assign noise.valid   = vld_s[LAT];
	assign noise.noise_x = out_s14[0];
	assign noise.noise_y = out_s14[1];
	assign noise.noise_z = out_s14[2];

endmodule
